>>> hdl/crc16_checked_frame_receiver_top_assert.svh
// Assertion macros for the CRC-16 frame receiver.
`ifndef CRC16_CHECKED_FRAME_RECEIVER_TOP_ASSERT_SVH
`define CRC16_CHECKED_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CRCFR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CRCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/crcfr_pkg.sv
// Shared types, constants and the CRC byte update for the frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package crcfr_pkg;

    localparam int NUM_WORDS_DEF = 8;
    localparam int IDX_W         = 5;
    localparam int FIFO_DEPTH    = 4;

    localparam logic [7:0]  PREAMBLE = 8'd16;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_PRE = 2'd1;
    localparam logic [1:0] ST_BAD_CRC = 2'd2;

    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in;

    typedef struct packed {
        logic [15:0] word;
        logic [2:0]  word_index;
        logic [1:0]  status;
        logic        last;
    } t_out;

    typedef struct packed {
        logic             kind;
        logic [15:0]      word;
        logic [IDX_W-1:0] idx;
        logic [1:0]       status;
    } t_cmd;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/crcfr_front.sv
// Front end: tracks frame position, runs the CRC and issues store and verdict commands.
`timescale 1ns / 1ps
`default_nettype none

module crcfr_front #(
    parameter int NUM_WORDS = crcfr_pkg::NUM_WORDS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    output logic                o_full,
    input  wire crcfr_pkg::t_in i_in,
    output logic                o_cmd_push,
    input  wire logic           i_cmd_full,
    output crcfr_pkg::t_cmd     o_cmd
);

    localparam int FRAME_LEN = 2 * NUM_WORDS + 4;
    localparam int PW        = $clog2(FRAME_LEN);

    logic [PW-1:0] r_pos, n_pos;
    logic [15:0]   r_crc, n_crc;
    logic          r_pre_ok, n_pre_ok;
    logic [7:0]    r_hi;
    logic [7:0]    r_crc_lo;

    logic          accept;
    logic [PW-1:0] pos;
    logic [PW-1:0] off;
    logic          in_words;
    logic          crc_ok;

    assign o_full   = i_cmd_full;
    assign accept   = i_push && !i_cmd_full;
    assign pos      = i_in.frame_start ? '0 : r_pos;
    assign off      = pos - PW'(2);
    assign in_words = (pos >= PW'(2)) && (pos < PW'(2 + 2 * NUM_WORDS));
    assign crc_ok   = (r_crc_lo == r_crc[7:0]) && (i_in.data_byte == r_crc[15:8]);

    always_comb begin
        n_pos    = (pos == PW'(FRAME_LEN - 1)) ? '0 : pos + PW'(1);
        n_crc    = r_crc;
        n_pre_ok = r_pre_ok;
        if (pos == '0) begin
            n_crc    = crcfr_pkg::CRC_INIT;
            n_pre_ok = 1'b0;
        end else if (pos == PW'(1)) begin
            n_pre_ok = (i_in.data_byte == crcfr_pkg::PREAMBLE);
        end else if (in_words) begin
            n_crc = crcfr_pkg::crc_byte(r_crc, i_in.data_byte);
        end
    end

    always_comb begin
        o_cmd_push   = 1'b0;
        o_cmd.kind   = crcfr_pkg::KIND_WRITE;
        o_cmd.word   = {r_hi, i_in.data_byte};
        o_cmd.idx    = crcfr_pkg::IDX_W'(off >> 1);
        o_cmd.status = crcfr_pkg::ST_OK;
        if (accept && in_words && off[0]) begin
            o_cmd_push = 1'b1;
        end else if (accept && pos == PW'(FRAME_LEN - 1)) begin
            o_cmd_push = 1'b1;
            o_cmd.kind = crcfr_pkg::KIND_VERDICT;
            if (!r_pre_ok) begin
                o_cmd.status = crcfr_pkg::ST_BAD_PRE;
            end else if (!crc_ok) begin
                o_cmd.status = crcfr_pkg::ST_BAD_CRC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_crc    <= crcfr_pkg::CRC_INIT;
            r_pre_ok <= 1'b0;
        end else if (accept) begin
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_pre_ok <= n_pre_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && in_words && !off[0]) begin
            r_hi <= i_in.data_byte;
        end
        if (accept && pos == PW'(FRAME_LEN - 2)) begin
            r_crc_lo <= i_in.data_byte;
        end
    end

endmodule

`default_nettype wire

>>> hdl/crcfr_fifo.sv
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module crcfr_fifo #(
    parameter int DEPTH = crcfr_pkg::FIFO_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    output logic                 o_full,
    input  wire crcfr_pkg::t_cmd i_data,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output crcfr_pkg::t_cmd      o_data
);

    localparam int AW = $clog2(DEPTH);

    crcfr_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [AW:0]     r_cnt, n_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == (AW + 1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + (AW + 1)'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - (AW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/crcfr_back.sv
// Back end: word store, verdict handling and the result output register.
`timescale 1ns / 1ps
`default_nettype none

module crcfr_back #(
    parameter int NUM_WORDS = crcfr_pkg::NUM_WORDS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cmd_empty,
    output logic                 o_cmd_pop,
    input  wire crcfr_pkg::t_cmd i_cmd,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output crcfr_pkg::t_out      o_out
);

    localparam int IW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    logic [15:0]     r_store [NUM_WORDS];
    logic            r_emit, n_emit;
    logic [IW-1:0]   r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;
    crcfr_pkg::t_out r_out, n_out;
    logic            out_load;
    logic            is_write;
    logic            load_out;

    assign o_empty  = !r_out_valid;
    assign o_out    = r_out;
    assign out_load = !r_out_valid || i_pop;
    assign is_write = (i_cmd.kind == crcfr_pkg::KIND_WRITE);

    always_comb begin
        o_cmd_pop   = 1'b0;
        n_emit      = r_emit;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        load_out    = 1'b0;
        if (r_emit) begin
            if (out_load) begin
                load_out         = 1'b1;
                n_out_valid      = 1'b1;
                n_out.word       = r_store[r_cnt];
                n_out.word_index = 3'(r_cnt);
                n_out.status     = crcfr_pkg::ST_OK;
                n_out.last       = (r_cnt == IW'(NUM_WORDS - 1));
                n_cnt            = r_cnt + IW'(1);
                if (r_cnt == IW'(NUM_WORDS - 1)) begin
                    n_emit = 1'b0;
                end
            end
        end else if (!i_cmd_empty) begin
            if (is_write) begin
                o_cmd_pop = 1'b1;
            end else if (i_cmd.status == crcfr_pkg::ST_OK) begin
                o_cmd_pop = 1'b1;
                n_emit    = 1'b1;
                n_cnt     = '0;
            end else if (out_load) begin
                o_cmd_pop        = 1'b1;
                load_out         = 1'b1;
                n_out_valid      = 1'b1;
                n_out.word       = '0;
                n_out.word_index = '0;
                n_out.status     = i_cmd.status;
                n_out.last       = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_emit      <= n_emit;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= n_out;
        end
        if (o_cmd_pop && is_write) begin
            r_store[IW'(i_cmd.idx)] <= i_cmd.word;
        end
    end

endmodule

`default_nettype wire

>>> hdl/crc16_checked_frame_receiver_top.sv
// CRC-16/Modbus checked frame receiver, top level.
// Input channel: one frame byte per word, accepted when i_push is high and
// o_full is low. i_in.frame_start marks byte 0 of a frame; otherwise the
// position wraps after 2*NUM_WORDS+4 bytes. Byte 1 must be 16, the words
// follow high byte first, and the last two bytes hold the CRC, low first.
// Result channel: o_out is valid while o_empty is low and is taken with
// i_pop. A good frame gives NUM_WORDS words with status 0, the last one
// flagged; a bad preamble (1) or CRC mismatch (2) gives one word with last.
// Throughput: one byte per cycle while o_full is low. The back end drains
// a good frame well inside a frame time.
// Path: a good frame's first word goes through the command queue, emit flag
// and output register once the last CRC byte is taken, an error word skips
// the emit flag; later words follow one per cycle while i_pop is held.
// Stalls: when the result side stops popping, the command queue between
// front and back fills and o_full rises; no byte is lost.
// Reset: synchronous, active low; clears position, CRC, queue, out valid.
`timescale 1ns / 1ps
`default_nettype none
`include "crc16_checked_frame_receiver_top_assert.svh"

module crc16_checked_frame_receiver_top #(
    parameter int NUM_WORDS = crcfr_pkg::NUM_WORDS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    output logic                 o_full,
    input  wire crcfr_pkg::t_in  i_in,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output crcfr_pkg::t_out      o_out
);

    // room for the next frame's word writes while a good frame drains
    localparam int CMD_DEPTH = (NUM_WORDS / 2 > crcfr_pkg::FIFO_DEPTH)
                             ? (1 << $clog2(NUM_WORDS / 2)) : crcfr_pkg::FIFO_DEPTH;

    logic            cmd_push, cmd_full, cmd_empty, cmd_pop;
    crcfr_pkg::t_cmd cmd_in, cmd_out;
    logic            out_err, err_shape_ok, status_known;

    assign out_err      = !o_empty && o_out.status != crcfr_pkg::ST_OK;
    assign err_shape_ok = o_out.last && o_out.word == 16'd0 && o_out.word_index == 3'd0;
    assign status_known = o_out.status == crcfr_pkg::ST_OK
                       || o_out.status == crcfr_pkg::ST_BAD_PRE
                       || o_out.status == crcfr_pkg::ST_BAD_CRC;

    crcfr_front #(.NUM_WORDS(NUM_WORDS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_in       (i_in),
        .o_cmd_push (cmd_push),
        .i_cmd_full (cmd_full),
        .o_cmd      (cmd_in)
    );

    crcfr_fifo #(.DEPTH(CMD_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .o_full  (cmd_full),
        .i_data  (cmd_in),
        .o_empty (cmd_empty),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out)
    );

    crcfr_back #(.NUM_WORDS(NUM_WORDS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd_out),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out       (o_out)
    );

    `CRCFR_ASSERT_IMPL(a_no_push_full, cmd_push, !cmd_full, "command pushed into full queue")
    `CRCFR_ASSERT_IMPL(a_err_shape, out_err, err_shape_ok, "malformed error word")
    `CRCFR_ASSERT_IMPL(a_status_code, !o_empty, status_known, "bad status code")

endmodule

`default_nettype wire

>>> sim/crc16_checked_frame_receiver_top_tb.sv
// Self-checking testbench for the CRC-16/Modbus checked frame receiver.
`timescale 1ns / 1ps

module crc16_checked_frame_receiver_top_tb;

    localparam int NW          = crcfr_pkg::NUM_WORDS_DEF;
    localparam int FRAME_BYTES = 2 * NW + 4;
    localparam int RAND_BYTES  = 160;
    localparam int HOLD_CYCLES = 150;
    localparam int MAX_SHOWN   = 10;
    localparam int SEND_IDLE [4] = '{0, 71, 0, 15};
    localparam int RX_STALL  [4] = '{0, 0, 71, 15};

    typedef enum logic [2:0] {FR_GOOD, FR_BAD_PRE, FR_BAD_CRC, FR_BAD_BOTH, FR_CUT} t_frame_kind;
    typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RAMP, FILL_RAND} t_fill;

    typedef struct {
        t_frame_kind kind;
        t_fill       fill;
        bit          use_start;
        bit          typed;
        logic [1:0]  typed_status;
    } t_frame_row;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_push;
    logic            i_pop = 1'b0;
    crcfr_pkg::t_in  i_in;
    logic            o_full;
    logic            o_empty;
    crcfr_pkg::t_out o_out;

    crc16_checked_frame_receiver_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_in    (i_in),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_out   (o_out)
    );

    always #1 i_clk = ~i_clk;

    // frame decoder model state
    int unsigned fm_pos;
    logic [15:0] fm_crc;
    logic        fm_pre_ok;
    logic [7:0]  fm_hi;
    logic [7:0]  fm_crc_lo;
    logic [15:0] fm_words [NW];

    crcfr_pkg::t_out step_words [$];
    crcfr_pkg::t_out pending_words [$];

    int err_count     = 0;
    int n_bytes       = 0;
    int n_ok_words    = 0;
    int n_pre_err     = 0;
    int n_crc_err     = 0;
    int send_idle_pct = 0;
    int rx_stall_pct  = 0;
    bit rx_hold       = 1'b0;
    bit hold_go       = 1'b0;

    t_frame_row dir_rows [8] = '{
        '{FR_GOOD,     FILL_ZERO, 1'b0, 1'b0, crcfr_pkg::ST_OK},  // right after reset, no start
        '{FR_GOOD,     FILL_ONES, 1'b0, 1'b0, crcfr_pkg::ST_OK},  // position wraps by itself
        '{FR_BAD_PRE,  FILL_RAMP, 1'b1, 1'b1, crcfr_pkg::ST_BAD_PRE},
        '{FR_BAD_PRE,  FILL_ONES, 1'b1, 1'b1, crcfr_pkg::ST_BAD_PRE},
        '{FR_BAD_CRC,  FILL_ONES, 1'b1, 1'b1, crcfr_pkg::ST_BAD_CRC},
        '{FR_BAD_BOTH, FILL_ZERO, 1'b1, 1'b1, crcfr_pkg::ST_BAD_PRE}, // preamble error wins
        '{FR_CUT,      FILL_RAMP, 1'b1, 1'b0, crcfr_pkg::ST_OK},
        '{FR_GOOD,     FILL_RAMP, 1'b1, 1'b0, crcfr_pkg::ST_OK}   // restart drops partial frame
    };

    function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ crcfr_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic s);
        int unsigned p;
        int unsigned off;
        logic        crc_good;
        step_words.delete();
        p = s ? 0 : fm_pos;
        if (p >= FRAME_BYTES) p = 0;
        if (p == 0) begin
            fm_crc    = crcfr_pkg::CRC_INIT;
            fm_pre_ok = 1'b0;
        end else if (p == 1) begin
            fm_pre_ok = (b == crcfr_pkg::PREAMBLE);
        end else if (p < FRAME_BYTES - 2) begin
            off    = p - 2;
            fm_crc = crc16_next(fm_crc, b);
            if (off[0] == 1'b0) begin
                fm_hi = b;
            end else begin
                fm_words[off >> 1] = {fm_hi, b};
            end
        end else if (p == FRAME_BYTES - 2) begin
            fm_crc_lo = b;
        end else begin
            crc_good = (fm_crc_lo == fm_crc[7:0]) && (b == fm_crc[15:8]);
            if (!fm_pre_ok) begin
                step_words.push_back(crcfr_pkg::t_out'{word: 16'h0, word_index: 3'd0,
                                     status: crcfr_pkg::ST_BAD_PRE, last: 1'b1});
            end else if (!crc_good) begin
                step_words.push_back(crcfr_pkg::t_out'{word: 16'h0, word_index: 3'd0,
                                     status: crcfr_pkg::ST_BAD_CRC, last: 1'b1});
            end else begin
                for (int k = 0; k < NW; k++) begin
                    step_words.push_back(crcfr_pkg::t_out'{word: fm_words[k],
                                         word_index: 3'(k), status: crcfr_pkg::ST_OK,
                                         last: (k == NW - 1)});
                end
            end
        end
        fm_pos = (p + 1 >= FRAME_BYTES) ? 0 : p + 1;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic s, input bit typed,
                             input crcfr_pkg::t_out typed_res);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_in   <= '{data_byte: b, frame_start: s};
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        decode_byte(b, s);
        if (typed && step_words.size() != 0) begin
            pending_words.push_back(typed_res);
        end else begin
            foreach (step_words[k]) pending_words.push_back(step_words[k]);
        end
        n_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input t_frame_kind kind, input t_fill fill, input bit use_start,
                              input bit typed, input logic [1:0] typed_status);
        logic [7:0]      fb [FRAME_BYTES];
        logic [15:0]     crc;
        logic [15:0]     w;
        crcfr_pkg::t_out err_word;
        int              n;
        err_word = '{word: 16'h0, word_index: 3'd0, status: typed_status, last: 1'b1};
        case (fill)
            FILL_ZERO: fb[0] = 8'h00;
            FILL_ONES: fb[0] = 8'hFF;
            default:   fb[0] = 8'($urandom_range(0, 255));
        endcase
        fb[1] = crcfr_pkg::PREAMBLE;
        if (kind == FR_BAD_PRE || kind == FR_BAD_BOTH) begin
            case (fill)
                FILL_ZERO: fb[1] = 8'h00;
                FILL_ONES: fb[1] = 8'hFF;
                FILL_RAMP: fb[1] = crcfr_pkg::PREAMBLE + 8'd1;
                default: begin
                    do fb[1] = 8'($urandom_range(0, 255)); while (fb[1] == crcfr_pkg::PREAMBLE);
                end
            endcase
        end
        for (int i = 0; i < NW; i++) begin
            case (fill)
                FILL_ZERO: w = 16'h0000;
                FILL_ONES: w = 16'hFFFF;
                FILL_RAMP: w = {8'(2 * i), 8'(2 * i + 1)};
                default:   w = 16'($urandom);
            endcase
            fb[2 + 2 * i] = w[15:8];
            fb[3 + 2 * i] = w[7:0];
        end
        crc = crcfr_pkg::CRC_INIT;
        for (int i = 2; i < FRAME_BYTES - 2; i++) crc = crc16_next(crc, fb[i]);
        fb[FRAME_BYTES - 2] = crc[7:0];
        fb[FRAME_BYTES - 1] = crc[15:8];
        if (kind == FR_BAD_CRC || kind == FR_BAD_BOTH) begin
            if ($urandom_range(0, 1) == 0) begin
                fb[FRAME_BYTES - 2] ^= 8'($urandom_range(1, 255));
            end else begin
                fb[FRAME_BYTES - 1] ^= 8'($urandom_range(1, 255));
            end
        end
        n = (kind == FR_CUT) ? $urandom_range(2, FRAME_BYTES - 1) : FRAME_BYTES;
        for (int i = 0; i < n; i++) begin
            push_byte(fb[i], (i == 0) ? use_start : 1'b0, typed && (i == FRAME_BYTES - 1),
                      err_word);
        end
    endtask

    // result side
    always @(negedge i_clk) begin
        i_pop <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    always @(posedge i_clk) begin
        crcfr_pkg::t_out want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (pending_words.size() == 0) begin
                err_count++;
                if (err_count <= MAX_SHOWN)
                    $display("unexpected word: %h idx %0d status %0d last %0d",
                             o_out.word, o_out.word_index, o_out.status, o_out.last);
            end else begin
                want = pending_words.pop_front();
                if (o_out.word !== want.word || o_out.word_index !== want.word_index ||
                    o_out.status !== want.status || o_out.last !== want.last) begin
                    err_count++;
                    if (err_count <= MAX_SHOWN)
                        $display("mismatch: got %h/%0d/%0d/%0d, want %h/%0d/%0d/%0d",
                                 o_out.word, o_out.word_index, o_out.status, o_out.last,
                                 want.word, want.word_index, want.status, want.last);
                end else if (want.status == crcfr_pkg::ST_OK) begin
                    n_ok_words++;
                end else if (want.status == crcfr_pkg::ST_BAD_PRE) begin
                    n_pre_err++;
                end else begin
                    n_crc_err++;
                end
            end
        end
    end

    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int dir_bytes;
        int rand_sent;
        int pick;
        int waited;
        bit start;
        i_rst_n   = 1'b0;
        i_push    = 1'b0;
        i_in      = '0;
        fm_pos    = 0;
        fm_crc    = crcfr_pkg::CRC_INIT;
        fm_pre_ok = 1'b0;
        fm_hi     = 8'h00;
        fm_crc_lo = 8'h00;
        foreach (fm_words[k]) fm_words[k] = 16'h0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            send_frame(dir_rows[r].kind, dir_rows[r].fill, dir_rows[r].use_start,
                       dir_rows[r].typed, dir_rows[r].typed_status);
        end
        dir_bytes = n_bytes;

        rand_sent = 0;
        while (rand_sent < RAND_BYTES) begin
            send_idle_pct = SEND_IDLE[rand_sent * 4 / RAND_BYTES];
            rx_stall_pct  = RX_STALL[rand_sent * 4 / RAND_BYTES];
            hold_go       = 1'b1;
            start = (fm_pos != 0) || ($urandom_range(0, 1) == 1);
            pick  = $urandom_range(0, 99);
            if (pick < 65) begin
                send_frame(FR_GOOD, FILL_RAND, start, 1'b0, crcfr_pkg::ST_OK);
            end else if (pick < 75) begin
                send_frame(FR_BAD_PRE, FILL_RAND, start, 1'b0, crcfr_pkg::ST_BAD_PRE);
            end else if (pick < 85) begin
                send_frame(FR_BAD_CRC, FILL_RAND, start, 1'b0, crcfr_pkg::ST_BAD_CRC);
            end else if (pick < 90) begin
                send_frame(FR_BAD_BOTH, FILL_RAND, start, 1'b0, crcfr_pkg::ST_BAD_PRE);
            end else if (pick < 95) begin
                send_frame(FR_CUT, FILL_RAND, start, 1'b0, crcfr_pkg::ST_OK);
            end else begin
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b0, '0);
            end
            rand_sent = n_bytes - dir_bytes;
        end

        i_push        <= 1'b0;
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        waited        = 0;
        while (pending_words.size() != 0 && waited < 4000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (16) @(posedge i_clk);
        if (pending_words.size() != 0) begin
            err_count++;
            $display("%0d expected words never came out", pending_words.size());
        end

        $display("%0d bytes in; checked %0d good words, %0d preamble and %0d crc error words",
                 n_bytes, n_ok_words, n_pre_err, n_crc_err);
        $display("ran with no gaps, sender gaps, receiver stalls, both, and a %0d-cycle hold",
                 HOLD_CYCLES);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
